// ===== rtl/wspr_pkg.sv =====
// wspr_pkg: constants, types and helper functions of the wspr symbol encoder
`default_nettype none

package wspr_pkg;

   localparam int SYMBOL_COUNT = 162;
   localparam int MSG_BITS     = 50;
   localparam int CALL_BITS    = 28;
   localparam int LOC_BITS     = 22;
   localparam int CSR_WIDTH    = 48;

   localparam logic [31:0] POLY_A = 32'hF2D05351;
   localparam logic [31:0] POLY_B = 32'hE4613C47;

   localparam logic [7:0] LAST_INDEX = 8'(SYMBOL_COUNT - 1);

   typedef enum logic [1:0] {
      CSR_CALLSIGN = 2'd0,
      CSR_LOCATOR  = 2'd1,
      CSR_POWER    = 2'd2,
      CSR_UNUSED   = 2'd3
   } csr_index_type;

   // sync vector, symbol 0 is the leftmost bit
   localparam logic [0:SYMBOL_COUNT-1] SYNC_VEC = {
      32'b11000000_10001110_00100101_11100000,
      32'b00100101_00000010_11001101_00011010,
      32'b00011010_10101001_00101100_01101010,
      32'b00100000_10010011_10110011_01000111,
      32'b00000101_00110000_00011010_11000110,
      2'b00
   };

   // symbol position -> coded bit number feeding it
   typedef logic [7:0] perm_table_type [0:255];

   function automatic logic [7:0] bitrev8(input logic [7:0] v);
      logic [7:0] r;
      for (int k = 0; k < 8; k++) begin
         r[7-k] = v[k];
      end
      return r;
   endfunction

   function automatic perm_table_type build_perm();
      perm_table_type t;
      int             p;
      logic [7:0]     r;
      p = 0;
      for (int i = 0; i < 256; i++) begin
         t[i] = 8'd0;
      end
      for (int i = 0; i < 256; i++) begin
         r = bitrev8(8'(i));
         if (p < SYMBOL_COUNT && int'(r) < SYMBOL_COUNT) begin
            t[r] = 8'(p);
            p = p + 1;
         end
      end
      return t;
   endfunction

   localparam perm_table_type PERM_TABLE = build_perm();

   // callsign positions 1 and 2: digit, space or letter
   function automatic logic [CALL_BITS-1:0] alnum_code(input logic [7:0] c);
      logic [CALL_BITS-1:0] w;
      w = CALL_BITS'(c);
      if (c >= 8'h30 && c <= 8'h39) begin
         return w - CALL_BITS'(48);
      end else if (c == 8'h20) begin
         return CALL_BITS'(36);
      end
      return w - CALL_BITS'(65) + CALL_BITS'(10);
   endfunction

   // callsign positions 4 to 6: space or letter
   function automatic logic [CALL_BITS-1:0] letter_code(input logic [7:0] c);
      if (c == 8'h20) begin
         return CALL_BITS'(26);
      end
      return CALL_BITS'(c) - CALL_BITS'(65);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/wspr_symbol_encoder_top.sv =====
// wspr_symbol_encoder_top: pipelined wspr channel symbol lookup from packed message
//
// Usage: write callsign, locator and power over the csr port while the block
// is idle (csr_we with csr_index and csr_wdata, no wait). Then send symbol
// indexes on the req channel (valid/ready); each transfer returns one rsp item
// with the tone number 0..3 and a last flag set for index 161. Indexes of 162
// and above return symbol 0, last 0.
// A req transfer loads stage 1 and the item moves through each stage to the
// output register, which drives rsp_valid. Throughput: one item per cycle
// while rsp_ready is high; the five register stages (code/partial sums,
// packing multiply, message assembly, shift-register window select, parity
// and output) each take a new item whenever the stage ahead of them moves or
// is empty. Reset clears all stage valid bits and the three registers to zero.
// When the receiver stalls, the output stage holds its item and the stages
// behind it keep filling until every stage holds an item, then req_ready
// drops; nothing is lost or repeated.
`default_nettype none

module wspr_symbol_encoder_top
   import wspr_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [1:0]           csr_index,
   input  wire logic [CSR_WIDTH-1:0] csr_wdata,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [7:0]           req_symbol_index,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [1:0]                rsp_symbol,
   output logic                      rsp_last
);

   // configuration registers
   logic [47:0] callsign_ff;
   logic [31:0] locator_ff;
   logic [5:0]  power_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         callsign_ff <= '0;
         locator_ff  <= '0;
         power_ff    <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_CALLSIGN: callsign_ff <= csr_wdata;
            CSR_LOCATOR:  locator_ff  <= csr_wdata[31:0];
            CSR_POWER:    power_ff    <= csr_wdata[5:0];
            default:      ;
         endcase
      end
   end

   // stage valid bits and enables
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic s1_en, s2_en, s3_en, s4_en, s5_en;

   assign s5_en     = !s5_valid_ff || rsp_ready;
   assign s4_en     = !s4_valid_ff || s5_en;
   assign s3_en     = !s3_valid_ff || s4_en;
   assign s2_en     = !s2_valid_ff || s3_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_ready = s1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (s1_en) s1_valid_ff <= req_valid;
         if (s2_en) s2_valid_ff <= s1_valid_ff;
         if (s3_en) s3_valid_ff <= s2_valid_ff;
         if (s4_en) s4_valid_ff <= s3_valid_ff;
         if (s5_en) s5_valid_ff <= s4_valid_ff;
      end
   end

   // ---------------- stage 1: character codes and partial sums
   logic [CALL_BITS-1:0] x_in, y_in;
   logic [LOC_BITS-1:0]  la_in, lb_in;
   logic                 inr_in;
   logic                 sync_in;
   logic [7:0]           perm_in;

   always_comb begin
      x_in = alnum_code(callsign_ff[47:40]) * CALL_BITS'(36)
             + alnum_code(callsign_ff[39:32]);
      x_in = x_in * CALL_BITS'(10) + CALL_BITS'(callsign_ff[31:24]) - CALL_BITS'(48);
      y_in = letter_code(callsign_ff[23:16]) * CALL_BITS'(729)
             + letter_code(callsign_ff[15:8]) * CALL_BITS'(27)
             + letter_code(callsign_ff[7:0]);
      la_in = LOC_BITS'(179)
              - LOC_BITS'(10) * (LOC_BITS'(locator_ff[31:24]) - LOC_BITS'(65))
              - (LOC_BITS'(locator_ff[15:8]) - LOC_BITS'(48));
      lb_in = LOC_BITS'(10) * (LOC_BITS'(locator_ff[23:16]) - LOC_BITS'(65))
              + LOC_BITS'(locator_ff[7:0]) - LOC_BITS'(48);
      inr_in  = (req_symbol_index <= LAST_INDEX);
      sync_in = inr_in ? SYNC_VEC[req_symbol_index] : 1'b0;
      perm_in = PERM_TABLE[req_symbol_index];
   end

   logic [CALL_BITS-1:0] s1_x_ff, s1_y_ff;
   logic [LOC_BITS-1:0]  s1_la_ff, s1_lb_ff;
   logic                 s1_inr_ff, s1_sync_ff, s1_last_ff;
   logic [7:0]           s1_perm_ff;

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_x_ff    <= x_in;
         s1_y_ff    <= y_in;
         s1_la_ff   <= la_in;
         s1_lb_ff   <= lb_in;
         s1_inr_ff  <= inr_in;
         s1_sync_ff <= sync_in;
         s1_last_ff <= (req_symbol_index == LAST_INDEX);
         s1_perm_ff <= perm_in;
      end
   end

   // ---------------- stage 2: callsign and locator numbers
   logic [CALL_BITS-1:0] n_in;
   logic [LOC_BITS-1:0]  loc_in;

   assign n_in   = s1_x_ff * CALL_BITS'(19683) + s1_y_ff;
   assign loc_in = s1_la_ff * LOC_BITS'(180) + s1_lb_ff;

   logic [CALL_BITS-1:0] s2_n_ff;
   logic [LOC_BITS-1:0]  s2_loc_ff;
   logic                 s2_inr_ff, s2_sync_ff, s2_last_ff;
   logic [7:0]           s2_perm_ff;

   always_ff @(posedge clock) begin
      if (s2_en) begin
         s2_n_ff    <= n_in;
         s2_loc_ff  <= loc_in;
         s2_inr_ff  <= s1_inr_ff;
         s2_sync_ff <= s1_sync_ff;
         s2_last_ff <= s1_last_ff;
         s2_perm_ff <= s1_perm_ff;
      end
   end

   // ---------------- stage 3: 50-bit message
   logic [LOC_BITS-1:0] m_in;

   assign m_in = {s2_loc_ff[LOC_BITS-8:0], 7'b0} + LOC_BITS'(power_ff) + LOC_BITS'(64);

   logic [MSG_BITS-1:0] s3_msg_ff;
   logic                s3_inr_ff, s3_sync_ff, s3_last_ff;
   logic [7:0]          s3_perm_ff;

   always_ff @(posedge clock) begin
      if (s3_en) begin
         s3_msg_ff  <= {s2_n_ff, m_in};
         s3_inr_ff  <= s2_inr_ff;
         s3_sync_ff <= s2_sync_ff;
         s3_last_ff <= s2_last_ff;
         s3_perm_ff <= s2_perm_ff;
      end
   end

   // ---------------- stage 4: encoder shift register contents after the bit
   // stream with 31 zeros ahead of bit 0, message msb first, zero tail after
   logic [111:0] stream_w;
   logic [31:0]  window_w;
   logic [31:0]  shreg_in;

   always_comb begin
      stream_w = '0;
      for (int k = 0; k < MSG_BITS; k++) begin
         stream_w[k+31] = s3_msg_ff[MSG_BITS-1-k];
      end
      window_w = stream_w[s3_perm_ff[7:1] +: 32];
      for (int j = 0; j < 32; j++) begin
         shreg_in[j] = window_w[31-j];
      end
   end

   logic [31:0] s4_shreg_ff;
   logic        s4_second_ff, s4_inr_ff, s4_sync_ff, s4_last_ff;

   always_ff @(posedge clock) begin
      if (s4_en) begin
         s4_shreg_ff  <= shreg_in;
         s4_second_ff <= s3_perm_ff[0];
         s4_inr_ff    <= s3_inr_ff;
         s4_sync_ff   <= s3_sync_ff;
         s4_last_ff   <= s3_last_ff;
      end
   end

   // ---------------- stage 5: parity, sync and output register
   logic       coded_w;
   logic [1:0] symbol_in;

   always_comb begin
      coded_w   = s4_second_ff ? ^(s4_shreg_ff & POLY_B) : ^(s4_shreg_ff & POLY_A);
      symbol_in = s4_inr_ff ? {coded_w, s4_sync_ff} : 2'd0;
   end

   logic [1:0] s5_symbol_ff;
   logic       s5_last_ff;

   always_ff @(posedge clock) begin
      if (s5_en) begin
         s5_symbol_ff <= symbol_in;
         s5_last_ff   <= s4_last_ff;
      end
   end

   assign rsp_valid  = s5_valid_ff;
   assign rsp_symbol = s5_symbol_ff;
   assign rsp_last   = s5_last_ff;

endmodule

`default_nettype wire
